>>> rtl/tor_pkg.sv
// shared types and telnet byte codes for the option responder
`timescale 1ns / 1ps

package tor_pkg;

   localparam int unsigned MaxBurst = 6;
   localparam int unsigned CountW   = $clog2(MaxBurst + 1);
   localparam int unsigned IdxW     = $clog2(MaxBurst);

   localparam logic [7:0] TnIac  = 8'd255;
   localparam logic [7:0] TnDont = 8'd254;
   localparam logic [7:0] TnDo   = 8'd253;
   localparam logic [7:0] TnWont = 8'd252;
   localparam logic [7:0] TnWill = 8'd251;
   localparam logic [7:0] TnSb   = 8'd250;
   localparam logic [7:0] TnSe   = 8'd240;
   localparam logic [7:0] TnSend = 8'd1;
   localparam logic [7:0] TnIs   = 8'd0;

   localparam logic [7:0] OptEcho = 8'd1;
   localparam logic [7:0] OptSga  = 8'd3;

   // output bytes caused by one request, first byte in data[0]
   typedef struct packed {
      logic [CountW-1:0]           count;
      logic                        to_server;
      logic [MaxBurst-1:0][7:0]    data;
   } tor_burst_type;

endpackage

>>> rtl/tor_parser.sv
// telnet command parser: phase state and the reply bytes for each request
`timescale 1ns / 1ps

module tor_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             rx_byte,
   output tor_pkg::tor_burst_type burst
);
   import tor_pkg::*;

   localparam logic [2:0] PhText   = 3'd0;
   localparam logic [2:0] PhCmd    = 3'd1;
   localparam logic [2:0] PhOpt    = 3'd2;
   localparam logic [2:0] PhSbOpt  = 3'd3;
   localparam logic [2:0] PhSbMod  = 3'd4;
   localparam logic [2:0] PhSbBody = 3'd5;
   localparam logic [2:0] PhSbIac  = 3'd6;

   localparam logic [1:0] VerbWill = 2'd0;
   localparam logic [1:0] VerbWont = 2'd1;
   localparam logic [1:0] VerbDo   = 2'd2;
   localparam logic [1:0] VerbDont = 2'd3;

   logic [2:0] phase_ff, phase_in;
   logic [1:0] verb_ff, verb_in;
   logic [7:0] option_ff, option_in;
   logic [7:0] modifier_ff, modifier_in;
   logic [7:0] reply;
   logic       known_opt, known_held;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhText;
         verb_ff     <= VerbWill;
         option_ff   <= '0;
         modifier_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         verb_ff     <= verb_in;
         option_ff   <= option_in;
         modifier_ff <= modifier_in;
      end
   end

   assign known_opt  = (rx_byte == OptEcho) || (rx_byte == OptSga);
   assign known_held = (option_ff == OptEcho) || (option_ff == OptSga);

   always_comb begin
      if (known_opt) begin
         unique case (verb_ff)
            VerbWill: reply = TnDo;
            VerbWont: reply = TnDont;
            VerbDo:   reply = TnWill;
            VerbDont: reply = TnWont;
            default:  reply = TnWont;
         endcase
      end else begin
         reply = verb_ff[1] ? TnWont : TnDont;
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      verb_in         = verb_ff;
      option_in       = option_ff;
      modifier_in     = modifier_ff;
      burst.count     = '0;
      burst.to_server = 1'b0;
      burst.data      = '0;
      unique case (phase_ff)
         PhCmd: begin
            if (rx_byte == TnIac) begin
               burst.count   = CountW'(1);
               burst.data[0] = TnIac;
               phase_in      = PhText;
            end else if (rx_byte >= TnWill && rx_byte <= TnDont) begin
               verb_in  = 2'(rx_byte - TnWill);
               phase_in = PhOpt;
            end else if (rx_byte == TnSb) begin
               phase_in = PhSbOpt;
            end else begin
               phase_in = PhText;
            end
         end
         PhOpt: begin
            option_in       = rx_byte;
            burst.count     = CountW'(3);
            burst.to_server = 1'b1;
            burst.data[0]   = TnIac;
            burst.data[1]   = reply;
            burst.data[2]   = rx_byte;
            phase_in        = PhText;
         end
         PhSbOpt: begin
            option_in = rx_byte;
            phase_in  = PhSbMod;
         end
         PhSbMod: begin
            modifier_in = rx_byte;
            phase_in    = (rx_byte == TnIac) ? PhSbIac : PhSbBody;
         end
         PhSbBody: begin
            if (rx_byte == TnIac) phase_in = PhSbIac;
         end
         PhSbIac: begin
            if (rx_byte == TnSe) begin
               if (known_held && modifier_ff == TnSend) begin
                  burst.count     = CountW'(6);
                  burst.to_server = 1'b1;
                  burst.data[0]   = TnIac;
                  burst.data[1]   = TnSb;
                  burst.data[2]   = option_ff;
                  burst.data[3]   = TnIs;
                  burst.data[4]   = TnIac;
                  burst.data[5]   = TnSe;
               end
               phase_in = PhText;
            end else begin
               phase_in = PhSbBody;
            end
         end
         default: begin
            // text phase, and the unused code
            if (rx_byte == TnIac) begin
               phase_in = PhCmd;
            end else begin
               burst.count   = CountW'(1);
               burst.data[0] = rx_byte;
               phase_in      = PhText;
            end
         end
      endcase
   end

endmodule

>>> rtl/tor_burst.sv
// result buffer that plays out the bytes of one request in order
`timescale 1ns / 1ps

module tor_burst (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  tor_pkg::tor_burst_type burst,
   output logic                   free,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_byte,
   output logic                   out_to_server,
   output logic                   out_last
);
   import tor_pkg::*;

   logic                     valid_ff, valid_in;
   logic [CountW-1:0]        count_ff;
   logic [IdxW-1:0]          idx_ff, idx_in;
   logic                     srv_ff;
   logic [MaxBurst-1:0][7:0] data_ff;
   logic                     last;

   assign last     = (CountW'(idx_ff) == count_ff - CountW'(1));
   assign free     = !valid_ff || (out_ready && last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      priority if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (valid_ff && out_ready) begin
         if (last) valid_in = 1'b0;
         idx_in = idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= burst.count;
         srv_ff   <= burst.to_server;
         data_ff  <= burst.data;
      end
   end

   assign out_valid     = valid_ff;
   assign out_byte      = data_ff[idx_ff];
   assign out_to_server = srv_ff;
   assign out_last      = last;

endmodule

>>> rtl/telnet_option_responder.sv
// top level of the telnet option responder
`timescale 1ns / 1ps

// Takes one received telnet byte per request on the req_ stream and emits
// display text and negotiation replies on the rsp_ stream. Each rsp item
// carries one byte, a flag in tuser (0 display, 1 send to server) and tlast
// on the final byte caused by its request. A request causes zero, one,
// three or six rsp items; bytes that only advance the parser cause none.
// A request's first rsp item appears in the cycle after it is taken. While
// rsp_tready is high, a request is taken every cycle while each causes at
// most one item; a longer burst holds req_tready low, as the result buffer
// plays out one byte per cycle and takes the next request in the cycle its
// last byte leaves. When the receiver stalls, the buffer holds its byte and
// req_tready drops. Reset puts the parser in text phase and empties the buffer.
module telnet_option_responder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] to_server
   output logic       rsp_tlast
);
   import tor_pkg::*;

   tor_burst_type burst;
   logic          accept;
   logic          free;

   assign req_tready = free;
   assign accept     = req_tvalid && free;

   tor_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .burst   (burst)
   );

   tor_burst u_burst (
      .clock         (clock),
      .reset         (reset),
      .load          (accept && (burst.count != '0)),
      .burst         (burst),
      .free          (free),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_byte      (rsp_tdata),
      .out_to_server (rsp_tuser),
      .out_last      (rsp_tlast)
   );

endmodule
